[src/sma_crossover_detector_top_defines.svh]
// ----------------------------------------------------------------------------
// sma crossover detector assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SMA_CROSSOVER_DETECTOR_TOP_DEFINES_SVH
`define SMA_CROSSOVER_DETECTOR_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SMACD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SMACD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/smacd_pkg.sv]
// ----------------------------------------------------------------------------
// smacd_pkg
// shared widths, codes and stage flag types of the sma crossover detector
// ----------------------------------------------------------------------------
`default_nettype none

package smacd_pkg;

  localparam int MAX_WINDOW_DEF = 256;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 9;
  localparam int SIG_W    = 2;
  localparam int APB_DW   = 32;
  localparam int ADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  localparam int PERIOD_MIN = 2;

  localparam logic [PERIOD_W-1:0] SHORT_RST = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] LONG_RST  = PERIOD_W'(30);

  localparam logic [REG_IDX_W-1:0] REG_SHORT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_LONG  = REG_IDX_W'(1);

  typedef enum logic [SIG_W-1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_e;

  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_ABOVE = 2'd1,
    REL_BELOW = 2'd2
  } rel_e;

  // per-word control that travels down the pipeline
  typedef struct packed {
    logic clr;        // series start: sums and prior relation cleared first
    logic keep;       // both windows legal, sums are maintained
    logic sub_short;  // oldest short-window price leaves the sum
    logic sub_long;   // oldest long-window price leaves the sum
    logic use_cmp;    // both averages exist for this sample
    logic arm;        // both averages also existed for the previous sample
  } flags_t;

endpackage

`default_nettype wire

[src/smacd_ram.sv]
// ----------------------------------------------------------------------------
// smacd_ram
// generic single write, single read ram with registered read-first output
// ----------------------------------------------------------------------------
`default_nettype none

module smacd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // same-address read returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/smacd_front.sv]
// ----------------------------------------------------------------------------
// smacd_front
// input acceptance, ring pointer and sample count, history write and reads
// ----------------------------------------------------------------------------
`default_nettype none

module smacd_front #(
  parameter int MAX_WINDOW = smacd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_clr_i,
  input  wire logic                             ok_i,
  input  wire logic [smacd_pkg::PERIOD_W-1:0]   short_period_i,
  input  wire logic [smacd_pkg::PERIOD_W-1:0]   long_period_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [smacd_pkg::PRICE_W-1:0]    close_price_i,
  input  wire logic                             series_start_i,
  output logic                                  s1_valid_o,
  input  wire logic                             s1_ready_i,
  output logic      [smacd_pkg::PRICE_W-1:0]    s1_price_o,
  output smacd_pkg::flags_t                     s1_flags_o,
  output logic      [smacd_pkg::PRICE_W-1:0]    s1_old_short_o,
  output logic      [smacd_pkg::PRICE_W-1:0]    s1_old_long_o
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int NW = $clog2(MAX_WINDOW + 2);
  localparam int DW = (AW + 1 > smacd_pkg::PERIOD_W + 1) ? AW + 1 : smacd_pkg::PERIOD_W + 1;

  logic [AW-1:0] slot_q, slot_d, slot_cur;
  logic [NW-1:0] seen_q, seen_d, seen_cur;
  logic          accept;
  logic          s1_valid_q;
  logic [smacd_pkg::PRICE_W-1:0] price_q;
  smacd_pkg::flags_t flags_d, flags_q;
  logic [AW-1:0] addr_short, addr_long;

  // slot that lies back entries behind the write slot, modulo the ring depth
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] slot,
                                               input logic [smacd_pkg::PERIOD_W-1:0] back);
    logic [DW-1:0] diff;
    diff = DW'(slot) - DW'(back);
    if (diff[DW-1]) begin
      diff = diff + DW'(MAX_WINDOW);
    end
    return diff[AW-1:0];
  endfunction

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    slot_cur = series_start_i ? '0 : slot_q;
    seen_cur = series_start_i ? '0 : seen_q;
    slot_d   = (slot_cur == AW'(MAX_WINDOW - 1)) ? '0 : slot_cur + AW'(1);
    seen_d   = (32'(seen_cur) < 32'(MAX_WINDOW + 1)) ? seen_cur + NW'(1) : seen_cur;

    flags_d.clr       = series_start_i;
    flags_d.keep      = ok_i;
    flags_d.sub_short = ok_i && (32'(seen_cur) >= 32'(short_period_i));
    flags_d.sub_long  = ok_i && (32'(seen_cur) >= 32'(long_period_i));
    flags_d.use_cmp   = ok_i && (32'(seen_d) >= 32'(short_period_i))
                             && (32'(seen_d) >= 32'(long_period_i));
    flags_d.arm       = (32'(seen_d) > 32'(short_period_i))
                     && (32'(seen_d) > 32'(long_period_i));

    addr_short = ring_back(slot_cur, short_period_i);
    addr_long  = ring_back(slot_cur, long_period_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      seen_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_clr_i) begin
        slot_q <= '0;
        seen_q <= '0;
      end else if (accept) begin
        slot_q <= slot_d;
        seen_q <= seen_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= close_price_i;
      flags_q <= flags_d;
    end
  end

  // two copies of the history so both window tails are read for each accepted word
  smacd_ram #(
    .WIDTH (smacd_pkg::PRICE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram_short (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_cur),
    .wdata_i (close_price_i),
    .re_i    (accept),
    .raddr_i (addr_short),
    .rdata_o (s1_old_short_o)
  );

  smacd_ram #(
    .WIDTH (smacd_pkg::PRICE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram_long (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_cur),
    .wdata_i (close_price_i),
    .re_i    (accept),
    .raddr_i (addr_long),
    .rdata_o (s1_old_long_o)
  );

  assign s1_valid_o = s1_valid_q;
  assign s1_price_o = price_q;
  assign s1_flags_o = flags_q;

endmodule

`default_nettype wire

[src/smacd_accum.sv]
// ----------------------------------------------------------------------------
// smacd_accum
// running window sums, updated from the history words read for each sample
// ----------------------------------------------------------------------------
`default_nettype none

module smacd_accum #(
  parameter int MAX_WINDOW = smacd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         cfg_clr_i,
  input  wire logic                                         s1_valid_i,
  output logic                                              s1_ready_o,
  input  wire logic [smacd_pkg::PRICE_W-1:0]                s1_price_i,
  input  wire smacd_pkg::flags_t                            s1_flags_i,
  input  wire logic [smacd_pkg::PRICE_W-1:0]                s1_old_short_i,
  input  wire logic [smacd_pkg::PRICE_W-1:0]                s1_old_long_i,
  output logic                                              b_valid_o,
  input  wire logic                                         b_ready_i,
  output smacd_pkg::flags_t                                 b_flags_o,
  output logic [smacd_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0]  b_short_total_o,
  output logic [smacd_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0]  b_long_total_o
);

  localparam int SW = smacd_pkg::PRICE_W + $clog2(MAX_WINDOW);

  logic          take;
  logic          b_valid_q;
  logic [SW-1:0] short_q, short_d, short_base;
  logic [SW-1:0] long_q, long_d, long_base;
  smacd_pkg::flags_t flags_q;

  assign s1_ready_o = !b_valid_q || b_ready_i;
  assign take       = s1_valid_i && s1_ready_o;

  always_comb begin
    short_base = s1_flags_i.clr ? '0 : short_q;
    long_base  = s1_flags_i.clr ? '0 : long_q;
    short_d    = short_base;
    long_d     = long_base;
    if (s1_flags_i.keep) begin
      short_d = short_base + SW'(s1_price_i)
              - (s1_flags_i.sub_short ? SW'(s1_old_short_i) : '0);
      long_d  = long_base + SW'(s1_price_i)
              - (s1_flags_i.sub_long ? SW'(s1_old_long_i) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q   <= '0;
      long_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_clr_i) begin
        short_q <= '0;
        long_q  <= '0;
      end else if (take) begin
        short_q <= short_d;
        long_q  <= long_d;
      end
      if (s1_ready_o) begin
        b_valid_q <= s1_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flags_q <= s1_flags_i;
    end
  end

  // the running sums double as this stage's payload
  assign b_valid_o       = b_valid_q;
  assign b_flags_o       = flags_q;
  assign b_short_total_o = short_q;
  assign b_long_total_o  = long_q;

endmodule

`default_nettype wire

[src/smacd_judge.sv]
// ----------------------------------------------------------------------------
// smacd_judge
// cross-multiplied average compare, crossing decision and output register
// ----------------------------------------------------------------------------
`default_nettype none

module smacd_judge #(
  parameter int MAX_WINDOW = smacd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         cfg_clr_i,
  input  wire logic [smacd_pkg::PERIOD_W-1:0]               short_period_i,
  input  wire logic [smacd_pkg::PERIOD_W-1:0]               long_period_i,
  input  wire logic                                         b_valid_i,
  output logic                                              b_ready_o,
  input  wire smacd_pkg::flags_t                            b_flags_i,
  input  wire logic [smacd_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0] b_short_total_i,
  input  wire logic [smacd_pkg::PRICE_W+$clog2(MAX_WINDOW)-1:0] b_long_total_i,
  output logic                                              out_valid_o,
  input  wire logic                                         out_ready_i,
  output logic [smacd_pkg::SIG_W-1:0]                       signal_o
);

  localparam int SW = smacd_pkg::PRICE_W + $clog2(MAX_WINDOW);
  localparam int PW = SW + smacd_pkg::PERIOD_W;

  logic          take;
  logic          c_valid_q;
  logic          o_valid_q;
  logic          o_ready;
  logic [PW-1:0] prod_short_q, prod_long_q;
  smacd_pkg::flags_t  flags_q;
  smacd_pkg::rel_e    rel, prior_eff, prior_q;
  smacd_pkg::signal_e sig, signal_q;

  assign o_ready   = !o_valid_q || out_ready_i;
  assign b_ready_o = !c_valid_q || o_ready;
  assign take      = b_valid_i && b_ready_o;

  // short/s against long/l, compared as short*l against long*s
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_short_q <= PW'(b_short_total_i) * PW'(long_period_i);
      prod_long_q  <= PW'(b_long_total_i) * PW'(short_period_i);
      flags_q      <= b_flags_i;
    end
  end

  always_comb begin
    if (prod_short_q > prod_long_q) begin
      rel = smacd_pkg::REL_ABOVE;
    end else if (prod_short_q < prod_long_q) begin
      rel = smacd_pkg::REL_BELOW;
    end else begin
      rel = smacd_pkg::REL_EQUAL;
    end
    prior_eff = flags_q.clr ? smacd_pkg::REL_EQUAL : prior_q;
    sig = smacd_pkg::SIG_NONE;
    if (flags_q.use_cmp && flags_q.arm) begin
      if (rel == smacd_pkg::REL_ABOVE && prior_eff != smacd_pkg::REL_ABOVE) begin
        sig = smacd_pkg::SIG_BUY;
      end else if (rel == smacd_pkg::REL_BELOW && prior_eff != smacd_pkg::REL_BELOW) begin
        sig = smacd_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      prior_q   <= smacd_pkg::REL_EQUAL;
    end else begin
      if (b_ready_o) begin
        c_valid_q <= b_valid_i;
      end
      if (o_ready) begin
        o_valid_q <= c_valid_q;
      end
      if (cfg_clr_i) begin
        prior_q <= smacd_pkg::REL_EQUAL;
      end else if (o_ready && c_valid_q) begin
        if (flags_q.use_cmp) begin
          prior_q <= rel;
        end else if (flags_q.clr) begin
          prior_q <= smacd_pkg::REL_EQUAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && c_valid_q) begin
      signal_q <= sig;
    end
  end

  assign out_valid_o = o_valid_q;
  assign signal_o    = signal_q;

endmodule

`default_nettype wire

[src/sma_crossover_detector_top.sv]
// ----------------------------------------------------------------------------
// sma_crossover_detector_top
// short/long simple moving average crossover detector, one word per price
// input words carry close_price_i and series_start_i; each yields one output
// word with signal_o (none, buy on an upward cross, sell on a downward cross)
// an accepted word passes the front, accum, product and output registers to out_valid_o
// throughput: one word per cycle while out_ready_i is high, set by the two history
// reads and the ring write done together in the front stage (one ram copy per window tail)
// the four stages each hold one word; when out_ready_i is low the output
// register holds and earlier stages fill up before in_ready_o drops
// period registers sit on the apb port at 0x0 (short) and 0x4 (long); write
// them only while no word is in flight, every write restarts the series
// reset clears pointers, sums, valid flags and restores periods 10 and 30;
// the history ram is never cleared, only entries of the current series are read
// ----------------------------------------------------------------------------
`default_nettype none

`include "sma_crossover_detector_top_defines.svh"

module sma_crossover_detector_top #(
  parameter int MAX_WINDOW = smacd_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [smacd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [smacd_pkg::APB_DW-1:0]    pwdata,
  output logic      [smacd_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [smacd_pkg::PRICE_W-1:0]   close_price_i,
  input  wire logic                            series_start_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [smacd_pkg::SIG_W-1:0]     signal_o
);

  localparam int SW = smacd_pkg::PRICE_W + $clog2(MAX_WINDOW);

  logic [smacd_pkg::PERIOD_W-1:0]  short_q, long_q;
  logic [smacd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            cfg_wr;
  logic                            ok;

  logic                            s1_valid, s1_ready;
  logic [smacd_pkg::PRICE_W-1:0]   s1_price, s1_old_short, s1_old_long;
  smacd_pkg::flags_t               s1_flags;

  logic                            b_valid, b_ready;
  smacd_pkg::flags_t               b_flags;
  logic [SW-1:0]                   b_short_total, b_long_total;

  assign pready  = 1'b1;
  assign reg_idx = paddr[smacd_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= smacd_pkg::SHORT_RST;
      long_q  <= smacd_pkg::LONG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        smacd_pkg::REG_SHORT: begin
          short_q <= pwdata[smacd_pkg::PERIOD_W-1:0];
        end
        smacd_pkg::REG_LONG: begin
          long_q <= pwdata[smacd_pkg::PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      smacd_pkg::REG_SHORT: prdata = smacd_pkg::APB_DW'(short_q);
      smacd_pkg::REG_LONG:  prdata = smacd_pkg::APB_DW'(long_q);
      default:              prdata = '0;
    endcase
  end

  // both windows must lie in the supported range
  assign ok = (32'(short_q) >= 32'(smacd_pkg::PERIOD_MIN))
           && (32'(short_q) <= 32'(MAX_WINDOW))
           && (32'(long_q)  >= 32'(smacd_pkg::PERIOD_MIN))
           && (32'(long_q)  <= 32'(MAX_WINDOW));

  smacd_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_clr_i      (cfg_wr),
    .ok_i           (ok),
    .short_period_i (short_q),
    .long_period_i  (long_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .close_price_i  (close_price_i),
    .series_start_i (series_start_i),
    .s1_valid_o     (s1_valid),
    .s1_ready_i     (s1_ready),
    .s1_price_o     (s1_price),
    .s1_flags_o     (s1_flags),
    .s1_old_short_o (s1_old_short),
    .s1_old_long_o  (s1_old_long)
  );

  smacd_accum #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_clr_i       (cfg_wr),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_price_i      (s1_price),
    .s1_flags_i      (s1_flags),
    .s1_old_short_i  (s1_old_short),
    .s1_old_long_i   (s1_old_long),
    .b_valid_o       (b_valid),
    .b_ready_i       (b_ready),
    .b_flags_o       (b_flags),
    .b_short_total_o (b_short_total),
    .b_long_total_o  (b_long_total)
  );

  smacd_judge #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_judge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_clr_i       (cfg_wr),
    .short_period_i  (short_q),
    .long_period_i   (long_q),
    .b_valid_i       (b_valid),
    .b_ready_o       (b_ready),
    .b_flags_i       (b_flags),
    .b_short_total_i (b_short_total),
    .b_long_total_i  (b_long_total),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .signal_o        (signal_o)
  );

  `SMACD_ASSERT_NEXT(a_accept_fills_front, in_valid_i && in_ready_o, s1_valid, "accepted word lost before the ram stage")
  `SMACD_ASSERT_NEXT(a_front_holds_on_stall, s1_valid && !s1_ready, s1_valid && $stable(s1_price) && $stable(s1_old_short) && $stable(s1_old_long), "ram stage changed while stalled")
  `SMACD_ASSERT_SAME(a_signal_code_legal, out_valid_o, signal_o == smacd_pkg::SIG_NONE || signal_o == smacd_pkg::SIG_BUY || signal_o == smacd_pkg::SIG_SELL, "illegal signal code")

endmodule

`default_nettype wire

[tb/tb_sma_crossover_detector_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sma_crossover_detector_top
// drives close prices through the crossover detector with random gaps and
// output stalls, predicts every signal word from a local model of the two
// running windows and checks each output word in order; period registers are
// written over apb between phases, covering the window extremes and the
// disabled settings
// ----------------------------------------------------------------------------

module tb_sma_crossover_detector_top;
  import smacd_pkg::*;

  localparam int HOLD_AT   = 800;  // accepted words before the long output stall
  localparam int HOLD_LEN  = 300;  // cycles of that stall
  localparam int CALM_LO   = 250;  // accepted-word window with no idling
  localparam int CALM_HI   = 450;
  localparam int N_DIRECT  = 22;
  localparam int N_PHASES  = 11;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               start;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PRICE_W-1:0] close_price_i = '0;
  logic series_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SIG_W-1:0] signal_o;

  sma_crossover_detector_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .close_price_i  (close_price_i),
    .series_start_i (series_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .signal_o       (signal_o)
  );

  // ticks waiting to be driven and signals waiting to come out
  tick_t   tick_q[$];
  signal_e signal_expect_q[$];
  int      accepted_cnt = 0;
  int      errors = 0;
  bit      word_taken = 1'b0;
  int      hold_cnt = 0;
  bit      hold_done = 1'b0;

  // local copy of the detector state
  logic [PERIOD_W-1:0] cfg_short = SHORT_RST;
  logic [PERIOD_W-1:0] cfg_long  = LONG_RST;
  logic [PRICE_W-1:0]  price_ring [MAX_WINDOW_DEF];
  logic [7:0]          ring_wr;
  int                  ring_fill;
  logic [39:0]         short_sum;
  logic [39:0]         long_sum;
  rel_e                last_rel;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit window_ok(input logic [PERIOD_W-1:0] p);
    return p >= PERIOD_W'(PERIOD_MIN) && p <= PERIOD_W'(MAX_WINDOW_DEF);
  endfunction

  function automatic void restart_series();
    ring_wr   = '0;
    ring_fill = 0;
    short_sum = '0;
    long_sum  = '0;
    last_rel  = REL_EQUAL;
  endfunction

  function automatic signal_e sma_step(input logic [PRICE_W-1:0] price, input logic start);
    signal_e     sig;
    rel_e        rel;
    logic [48:0] lhs;
    logic [48:0] rhs;
    bit          live;
    int          sp;
    int          lp;
    sig = SIG_NONE;
    sp  = int'(cfg_short);
    lp  = int'(cfg_long);
    if (start) restart_series();
    live = window_ok(cfg_short) && window_ok(cfg_long);
    if (live) begin
      short_sum += 40'(price);
      long_sum  += 40'(price);
      // a window of 256 wraps onto the slot about to be overwritten
      if (ring_fill >= sp) short_sum -= 40'(price_ring[8'(ring_wr - cfg_short[7:0])]);
      if (ring_fill >= lp) long_sum  -= 40'(price_ring[8'(ring_wr - cfg_long[7:0])]);
    end
    price_ring[ring_wr] = price;
    ring_wr = ring_wr + 8'd1;
    if (ring_fill < MAX_WINDOW_DEF + 1) ring_fill++;
    if (live && ring_fill >= sp && ring_fill >= lp) begin
      // short/sp vs long/lp, compared as short*lp vs long*sp
      lhs = 49'(short_sum) * 49'(cfg_long);
      rhs = 49'(long_sum) * 49'(cfg_short);
      rel = (lhs > rhs) ? REL_ABOVE : ((lhs < rhs) ? REL_BELOW : REL_EQUAL);
      if (ring_fill > sp && ring_fill > lp) begin
        if (rel == REL_ABOVE && last_rel != REL_ABOVE) sig = SIG_BUY;
        else if (rel == REL_BELOW && last_rel != REL_BELOW) sig = SIG_SELL;
      end
      last_rel = rel;
    end
    return sig;
  endfunction

  // output check first, then the input word taken at the same edge
  always @(posedge clk_i) begin
    signal_e want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (signal_expect_q.size() == 0) begin
          $display("%0t: output word with none expected, actual signal %0d",
                   $time, signal_o);
          errors++;
        end else begin
          want = signal_expect_q.pop_front();
          if (signal_o !== want) begin
            $display("%0t: signal mismatch, expected %0d actual %0d",
                     $time, want, signal_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        signal_expect_q.push_back(sma_step(close_price_i, series_start_i));
        accepted_cnt++;
        word_taken = 1'b1;
      end
    end
  end

  // price driver
  always @(negedge clk_i) begin
    bit    free;
    bit    calm;
    tick_t t;
    free = !in_valid_i || word_taken;
    word_taken = 1'b0;
    calm = (accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI) || hold_cnt != 0;
    if (rst_ni && free) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
        t = tick_q.pop_front();
        close_price_i  <= t.price;
        series_start_i <= t.start;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // signal receiver, with one long hold-off once the stream is well under way
  always @(negedge clk_i) begin
    bit rdy;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      rdy = 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      rdy = 1'b0;
    end else if (accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI) begin
      rdy = 1'b1;
    end else begin
      rdy = $urandom_range(0, 99) >= 37;
    end
    out_ready_i <= rdy;
  end

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid_i || signal_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // write a period register, update the model, then read it back
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [ADDR_W-1:0] addr;
    logic [APB_DW-1:0] data;
    logic [APB_DW-1:0] back;
    addr = ADDR_W'(idx) << 2;
    data = (APB_DW'($urandom) & ~APB_DW'(32'h1FF)) | APB_DW'(value[8:0]);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_SHORT) cfg_short = data[8:0];
    else cfg_long = data[8:0];
    restart_series();
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    back = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== APB_DW'(data[8:0])) begin
      $display("%0t: period readback at 0x%0h, expected %0d actual %0d",
               $time, addr, data[8:0], back);
      errors++;
    end
  endtask

  // random-walk prices with flat runs, jumps to the rails and rare restarts
  task automatic queue_phase(input int sp, input int lp, input int count);
    longint walk;
    int     step;
    int     pick;
    int     start_pm;
    tick_t  t;
    wait_idle();
    if (sp != int'(cfg_short) || $urandom_range(0, 1)) reg_write(REG_SHORT, sp);
    if (lp != int'(cfg_long) || $urandom_range(0, 1)) reg_write(REG_LONG, lp);
    start_pm = (sp > 64 || lp > 64) ? 2 : 20;
    walk = longint'($urandom);
    step = 1 << $urandom_range(0, 24);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        walk = $urandom_range(0, 1) ? 64'd0 : 64'hFFFF_FFFF;
      end else if (pick < 9) begin
        walk = longint'($urandom);
      end else if (pick >= 20) begin
        walk += longint'($urandom_range(0, 2 * step)) - longint'(step);
        if (walk < 0) walk = 0;
        if (walk > 64'hFFFF_FFFF) walk = 64'hFFFF_FFFF;
      end
      t.price = walk[31:0];
      t.start = (k == 0 && $urandom_range(0, 1)) || $urandom_range(0, 999) < start_pm;
      tick_q.push_back(t);
    end
  endtask

  logic [PRICE_W-1:0] dir_price [N_DIRECT] = '{
    32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0, 32'h0, 32'h0, 32'd5, 32'd6, 32'd7, 32'd8, 32'd8, 32'd8, 32'd8,
    32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'h0
  };
  bit dir_start [N_DIRECT] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0
  };
  // short, long, ticks; phases with both periods zero draw them at random
  int phase_sp [N_PHASES] = '{2, 10, 256, 2, 0, 1, 5, 511, 0, 0, 0};
  int phase_lp [N_PHASES] = '{3, 30, 2, 256, 5, 1, 257, 511, 0, 0, 0};
  int phase_n  [N_PHASES] = '{200, 300, 350, 350, 40, 30, 40, 30, 100, 100, 100};

  initial begin
    tick_t t;
    int    sp;
    int    lp;
    restart_series();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    // directed: equal, upward and downward crosses, flat runs, restarts, rails
    reg_write(REG_SHORT, 2);
    reg_write(REG_LONG, 3);
    for (int k = 0; k < N_DIRECT; k++) begin
      t.price = dir_price[k];
      t.start = dir_start[k];
      tick_q.push_back(t);
    end
    for (int p = 0; p < N_PHASES; p++) begin
      sp = phase_sp[p];
      lp = phase_lp[p];
      if (phase_sp[p] == 0 && phase_lp[p] == 0) begin
        sp = $urandom_range(2, 40);
        lp = $urandom_range(2, 40);
      end
      queue_phase(sp, lp, phase_n[p]);
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_sma_crossover_detector_top: PASS");
    end else begin
      $display("tb_sma_crossover_detector_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_sma_crossover_detector_top: FAIL");
    $finish;
  end

endmodule
